/* hdl/up_down_time_of_day_clock_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the up/down time-of-day clock
// Shared concurrent assertion shorthands, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef UP_DOWN_TIME_OF_DAY_CLOCK_MACROS_SVH
`define UP_DOWN_TIME_OF_DAY_CLOCK_MACROS_SVH

// Checked on every rising edge while reset is released.
`define UDTOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define UDTOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/udtod_pkg.sv */
// ---------------------------------------------------------------------------
// Time-of-day clock package
// Transaction types, input kind codes and range constants.
// ---------------------------------------------------------------------------
`default_nettype none

package udtod_pkg;

  // Kind of an input transaction.
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_SET_TIME   = 2'd1,
    KIND_SET_FORMAT = 2'd2,
    KIND_SET_RUN    = 2'd3
  } kind_e;

  // Configuration register byte addresses.
  localparam int unsigned ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_COUNT_DOWN = 2'd0;

  // Range limits of the time fields.
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [4:0] HOUR_NOON = 5'd12;
  localparam logic [4:0] HOUR_ELEVEN = 5'd11;
  localparam logic [4:0] HOUR_ONE  = 5'd1;
  localparam logic [4:0] HOUR_ZERO = 5'd0;

  // Input transaction.
  typedef struct packed {
    kind_e      kind;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic       new_format_12h;
    logic       new_run;
  } in_t;

  // Result transaction; it is also the full clock state.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       pm;
    logic       format_12h;
    logic       running;
  } out_t;

endpackage

`default_nettype wire

/* hdl/udtod_step.sv */
// ---------------------------------------------------------------------------
// Time-of-day clock next-state logic
// Applies one input transaction to the current clock state.
// ---------------------------------------------------------------------------
`default_nettype none

module udtod_step (
  input  wire udtod_pkg::out_t state_i,
  input  wire udtod_pkg::in_t  item_i,
  input  wire logic            count_down_i,
  output udtod_pkg::out_t      state_o
);

  logic [4:0] hour_up;
  logic [4:0] hour_dn;
  logic [4:0] hour_set;
  logic [5:0] min_set;
  logic [5:0] sec_set;

  // AM/PM flips when the hour change lands on midnight or noon, or on the
  // hour just before them with a nonzero minute.
  function automatic logic meridiem_flip(input logic [4:0] h, input logic [5:0] m);
    logic on_mark;
    logic before_mark;
    on_mark     = (h == udtod_pkg::HOUR_ZERO) || (h == udtod_pkg::HOUR_NOON);
    before_mark = (h == udtod_pkg::HOUR_ELEVEN) || (h == udtod_pkg::HOUR_LAST);
    return (on_mark && (m == 6'd0)) || (before_mark && (m != 6'd0));
  endfunction

  // Hour candidates for a carry up or a borrow down.
  always_comb begin
    if (state_i.format_12h) begin
      hour_up = (state_i.hour >= udtod_pkg::HOUR_NOON) ? udtod_pkg::HOUR_ONE
                                                        : state_i.hour + 5'd1;
      hour_dn = (state_i.hour <= udtod_pkg::HOUR_ONE) ? udtod_pkg::HOUR_NOON
                                                       : state_i.hour - 5'd1;
    end else begin
      hour_up = (state_i.hour >= udtod_pkg::HOUR_LAST) ? udtod_pkg::HOUR_ZERO
                                                        : state_i.hour + 5'd1;
      hour_dn = (state_i.hour == udtod_pkg::HOUR_ZERO) ? udtod_pkg::HOUR_LAST
                                                        : state_i.hour - 5'd1;
    end
  end

  // Saturated load values.
  always_comb begin
    hour_set = (item_i.hour_value > udtod_pkg::HOUR_LAST) ? udtod_pkg::HOUR_LAST
                                                          : item_i.hour_value;
    min_set  = (item_i.minute_value > udtod_pkg::MIN_LAST) ? udtod_pkg::MIN_LAST
                                                           : item_i.minute_value;
    sec_set  = (item_i.second_value > udtod_pkg::SEC_LAST) ? udtod_pkg::SEC_LAST
                                                           : item_i.second_value;
  end

  // Apply the transaction.
  always_comb begin
    state_o = state_i;
    case (item_i.kind)
      udtod_pkg::KIND_TICK: begin
        if (state_i.running) begin
          if (!count_down_i) begin
            if (state_i.second >= udtod_pkg::SEC_LAST) begin
              state_o.second = 6'd0;
              if (state_i.minute >= udtod_pkg::MIN_LAST) begin
                state_o.minute = 6'd0;
                state_o.hour   = hour_up;
                state_o.pm     = state_i.pm ^ meridiem_flip(hour_up, 6'd0);
              end else begin
                state_o.minute = state_i.minute + 6'd1;
              end
            end else begin
              state_o.second = state_i.second + 6'd1;
            end
          end else begin
            if (state_i.second == 6'd0) begin
              state_o.second = udtod_pkg::SEC_LAST;
              if (state_i.minute == 6'd0) begin
                state_o.minute = udtod_pkg::MIN_LAST;
                state_o.hour   = hour_dn;
                state_o.pm     = state_i.pm ^ meridiem_flip(hour_dn, udtod_pkg::MIN_LAST);
              end else begin
                state_o.minute = state_i.minute - 6'd1;
              end
            end else begin
              state_o.second = state_i.second - 6'd1;
            end
          end
        end
      end
      udtod_pkg::KIND_SET_TIME: begin
        state_o.hour   = hour_set;
        state_o.minute = min_set;
        state_o.second = sec_set;
        // An afternoon hour sets PM and folds in twelve-hour format.
        if (hour_set > udtod_pkg::HOUR_NOON) begin
          state_o.pm = 1'b1;
          if (state_i.format_12h) begin
            state_o.hour = hour_set - udtod_pkg::HOUR_NOON;
          end
        end
      end
      udtod_pkg::KIND_SET_FORMAT: begin
        if (item_i.new_format_12h) begin
          if (state_i.hour >= udtod_pkg::HOUR_NOON) begin
            state_o.hour = state_i.hour - udtod_pkg::HOUR_NOON;
            state_o.pm   = 1'b1;
          end
        end else if (state_i.format_12h && state_i.pm &&
                     (state_i.hour < udtod_pkg::HOUR_NOON)) begin
          state_o.hour = state_i.hour + udtod_pkg::HOUR_NOON;
        end
        state_o.format_12h = item_i.new_format_12h;
      end
      udtod_pkg::KIND_SET_RUN: begin
        state_o.running = item_i.new_run;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/up_down_time_of_day_clock.sv */
// ---------------------------------------------------------------------------
// Up/down time-of-day clock
// Hours, minutes and seconds with 12/24-hour format and a run control.
// ---------------------------------------------------------------------------
// Each input transaction (a one-second tick, a time load, a format switch or
// a start/stop command) returns one result holding the time after it. A
// transaction is captured in an input register and applied to the clock
// state when the result register takes it; one transaction is accepted
// every clock while the output side keeps up. The count direction comes
// from the count_down register at address 0 of the APB port; write it
// only while the block is idle.
`default_nettype none

module up_down_time_of_day_clock (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire udtod_pkg::in_t                   in_data_i,
  // Result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output udtod_pkg::out_t                       out_data_o,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [udtod_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

`include "up_down_time_of_day_clock_macros.svh"

  logic            count_down_q;
  logic            in_vld_q;
  logic            in_vld_d;
  udtod_pkg::in_t  in_q;
  logic            out_vld_q;
  logic            out_vld_d;
  udtod_pkg::out_t out_q;
  udtod_pkg::out_t state_q;
  udtod_pkg::out_t state_d;
  logic            out_free;
  logic            take_in;
  logic            move;
  logic            cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == udtod_pkg::REG_COUNT_DOWN);
  assign prdata = (paddr == udtod_pkg::REG_COUNT_DOWN) ? {31'd0, count_down_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_down_q <= 1'b0;
    end else if (cfg_wr) begin
      count_down_q <= pwdata[0];
    end
  end

  // Handshake control for the two register stages.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_free;
  assign take_in    = in_valid_i && !in_stall_o;
  assign move       = in_vld_q && out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take_in) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (move) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Next clock state from the captured transaction.
  udtod_step u_step (
    .state_i      (state_q),
    .item_i       (in_q),
    .count_down_i (count_down_q),
    .state_o      (state_d)
  );

  // Valid flags and clock state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (move) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_data_i;
    end
    if (move) begin
      out_q <= state_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The shown result is always the latest clock state.
  `UDTOD_ASSERT(a_result_is_state, out_vld_q |-> (out_q == state_q), "result differs from state")
  // Time fields stay in range.
  `UDTOD_ASSERT(a_time_range, (state_q.hour <= udtod_pkg::HOUR_LAST) &&
    (state_q.minute <= udtod_pkg::MIN_LAST) && (state_q.second <= udtod_pkg::SEC_LAST),
    "time field out of range")
  // Twelve-hour format never shows an hour past noon.
  `UDTOD_ASSERT(a_hour_12h, state_q.format_12h |-> (state_q.hour <= udtod_pkg::HOUR_NOON),
    "hour above 12 in twelve-hour format")
  // The input side stalls only with a transaction held.
  `UDTOD_ASSERT(a_stall_held, in_stall_o |-> (in_vld_q && out_vld_q), "stall without held data")
  // State changes only when a transaction moves into the result register.
  `UDTOD_ASSERT(a_state_hold, !$past(move) |-> $stable(state_q), "state changed without a move")
  // The configuration port never inserts wait states.
  `UDTOD_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the up/down time-of-day clock
// A short table of directed transactions covers the saturating loads, the
// hour wraps in both formats and both directions, and the format folds.
// Random phases follow, each with its own count direction. A predictor of
// the clock state checks every result, while both channels idle at random.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT    = 500_000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 213;
  localparam int unsigned DRAIN_PAUSE    = 6;
  localparam int unsigned MAX_REPORTS    = 10;

  // One row of the directed table: a direction write or a transaction,
  // with an optional expected result typed in by hand.
  typedef struct packed {
    logic            is_cfg;
    logic            cfg_down;
    udtod_pkg::in_t  item;
    logic            has_exp;
    udtod_pkg::out_t exp;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  udtod_pkg::in_t               in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  udtod_pkg::out_t              out_data;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [udtod_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Side band that travels with the driven transaction.
  logic                         exp_given = 1'b0;
  udtod_pkg::out_t              exp_typed = '0;

  // Predicted clock state and direction, and results still owed.
  udtod_pkg::out_t              clock_model = '0;
  logic                         model_down = 1'b0;
  udtod_pkg::out_t              owed_times [$];

  int unsigned       errors = 0;
  int unsigned       transactions_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       hour_changes = 0;
  int unsigned       direction_writes = 0;
  int unsigned       cycles = 0;
  int unsigned       fast_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       free_left = 0;

  up_down_time_of_day_clock u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Counts a failure and reports the first few.
  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Clock state after one transaction.
  function automatic udtod_pkg::out_t clock_after(udtod_pkg::out_t cur, udtod_pkg::in_t it,
                                                  logic down);
    udtod_pkg::out_t nxt;
    logic [4:0]      h;
    logic [5:0]      m;
    logic [5:0]      s;
    nxt = cur;
    case (it.kind)
      udtod_pkg::KIND_TICK: begin
        if (cur.running && !down) begin
          if (nxt.second >= udtod_pkg::SEC_LAST) begin
            nxt.second = '0;
            if (nxt.minute >= udtod_pkg::MIN_LAST) begin
              nxt.minute = '0;
              if (nxt.format_12h) begin
                nxt.hour = (nxt.hour >= udtod_pkg::HOUR_NOON) ? udtod_pkg::HOUR_ONE
                                                               : nxt.hour + 5'd1;
              end else begin
                nxt.hour = (nxt.hour >= udtod_pkg::HOUR_LAST) ? udtod_pkg::HOUR_ZERO
                                                               : nxt.hour + 5'd1;
              end
              // Counting up, the minute is zero: midnight and noon cross.
              if (nxt.hour == udtod_pkg::HOUR_ZERO || nxt.hour == udtod_pkg::HOUR_NOON)
                nxt.pm = ~nxt.pm;
            end else begin
              nxt.minute = nxt.minute + 6'd1;
            end
          end else begin
            nxt.second = nxt.second + 6'd1;
          end
        end else if (cur.running) begin
          if (nxt.second == '0) begin
            nxt.second = udtod_pkg::SEC_LAST;
            if (nxt.minute == '0) begin
              nxt.minute = udtod_pkg::MIN_LAST;
              if (nxt.format_12h) begin
                nxt.hour = (nxt.hour <= udtod_pkg::HOUR_ONE) ? udtod_pkg::HOUR_NOON
                                                              : nxt.hour - 5'd1;
              end else begin
                nxt.hour = (nxt.hour == udtod_pkg::HOUR_ZERO) ? udtod_pkg::HOUR_LAST
                                                               : nxt.hour - 5'd1;
              end
              // Counting down, the minute is 59: eleven and 23 cross.
              if (nxt.hour == udtod_pkg::HOUR_ELEVEN || nxt.hour == udtod_pkg::HOUR_LAST)
                nxt.pm = ~nxt.pm;
            end else begin
              nxt.minute = nxt.minute - 6'd1;
            end
          end else begin
            nxt.second = nxt.second - 6'd1;
          end
        end
      end
      udtod_pkg::KIND_SET_TIME: begin
        h = (it.hour_value > udtod_pkg::HOUR_LAST) ? udtod_pkg::HOUR_LAST : it.hour_value;
        m = (it.minute_value > udtod_pkg::MIN_LAST) ? udtod_pkg::MIN_LAST : it.minute_value;
        s = (it.second_value > udtod_pkg::SEC_LAST) ? udtod_pkg::SEC_LAST : it.second_value;
        if (h > udtod_pkg::HOUR_NOON) begin
          nxt.pm = 1'b1;
          if (nxt.format_12h) h = h - udtod_pkg::HOUR_NOON;
        end
        nxt.hour   = h;
        nxt.minute = m;
        nxt.second = s;
      end
      udtod_pkg::KIND_SET_FORMAT: begin
        if (it.new_format_12h) begin
          if (nxt.hour >= udtod_pkg::HOUR_NOON) begin
            nxt.hour = nxt.hour - udtod_pkg::HOUR_NOON;
            nxt.pm   = 1'b1;
          end
        end else if (nxt.format_12h && nxt.pm && nxt.hour < udtod_pkg::HOUR_NOON) begin
          nxt.hour = nxt.hour + udtod_pkg::HOUR_NOON;
        end
        nxt.format_12h = it.new_format_12h;
      end
      default: begin
        nxt.running = it.new_run;
      end
    endcase
    return nxt;
  endfunction

  // Lists the fields in which a result differs from its expectation.
  function automatic string diff_fields(udtod_pkg::out_t want, udtod_pkg::out_t got);
    string d;
    d = "";
    if (got.hour !== want.hour)
      d = {d, $sformatf(" hour exp %0d got %0d", want.hour, got.hour)};
    if (got.minute !== want.minute)
      d = {d, $sformatf(" minute exp %0d got %0d", want.minute, got.minute)};
    if (got.second !== want.second)
      d = {d, $sformatf(" second exp %0d got %0d", want.second, got.second)};
    if (got.pm !== want.pm)
      d = {d, $sformatf(" pm exp %0b got %0b", want.pm, got.pm)};
    if (got.format_12h !== want.format_12h)
      d = {d, $sformatf(" format_12h exp %0b got %0b", want.format_12h, got.format_12h)};
    if (got.running !== want.running)
      d = {d, $sformatf(" running exp %0b got %0b", want.running, got.running)};
    return d;
  endfunction

  function automatic udtod_pkg::in_t make_item(udtod_pkg::kind_e k, int h, int m, int s,
                                               int f, int r);
    udtod_pkg::in_t it;
    it.kind           = k;
    it.hour_value     = 5'(h);
    it.minute_value   = 6'(m);
    it.second_value   = 6'(s);
    it.new_format_12h = 1'(f);
    it.new_run        = 1'(r);
    return it;
  endfunction

  function automatic dir_row_t item_row(udtod_pkg::kind_e k, int h, int m, int s, int f,
                                        int r);
    dir_row_t row;
    row      = '0;
    row.item = make_item(k, h, m, s, f, r);
    return row;
  endfunction

  function automatic dir_row_t exp_row(udtod_pkg::kind_e k, int h, int m, int s, int f,
                                       int r, udtod_pkg::out_t want);
    dir_row_t row;
    row         = item_row(k, h, m, s, f, r);
    row.has_exp = 1'b1;
    row.exp     = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic down);
    dir_row_t row;
    row          = '0;
    row.is_cfg   = 1'b1;
    row.cfg_down = down;
    return row;
  endfunction

  // Random transaction: mostly ticks, with loads near the hour boundaries
  // so that the hour counter rolls often. Unused fields stay random.
  function automatic udtod_pkg::in_t random_item();
    udtod_pkg::in_t it;
    int unsigned    p;
    it.hour_value     = 5'($urandom);
    it.minute_value   = 6'($urandom);
    it.second_value   = 6'($urandom);
    it.new_format_12h = 1'($urandom);
    it.new_run        = 1'($urandom);
    p = $urandom_range(0, 99);
    if (p < 70) begin
      it.kind = udtod_pkg::KIND_TICK;
    end else if (p < 82) begin
      it.kind = udtod_pkg::KIND_SET_TIME;
      case ($urandom_range(0, 3))
        0, 1: begin
          case ($urandom_range(0, 5))
            0: it.hour_value = udtod_pkg::HOUR_ZERO;
            1: it.hour_value = udtod_pkg::HOUR_ONE;
            2: it.hour_value = udtod_pkg::HOUR_ELEVEN;
            3: it.hour_value = udtod_pkg::HOUR_NOON;
            4: it.hour_value = udtod_pkg::HOUR_NOON + 5'd1;
            default: it.hour_value = udtod_pkg::HOUR_LAST;
          endcase
          it.minute_value = ($urandom_range(0, 1) != 0) ? udtod_pkg::MIN_LAST : 6'd0;
          case ($urandom_range(0, 3))
            0: it.second_value = 6'd0;
            1: it.second_value = 6'd1;
            2: it.second_value = udtod_pkg::SEC_LAST - 6'd1;
            default: it.second_value = udtod_pkg::SEC_LAST;
          endcase
        end
        2: begin
          it.hour_value   = 5'($urandom_range(0, 23));
          it.minute_value = 6'($urandom_range(0, 59));
          it.second_value = 6'($urandom_range(0, 59));
        end
        default: begin
          // Raw bits, out-of-range values included.
        end
      endcase
    end else if (p < 90) begin
      it.kind = udtod_pkg::KIND_SET_FORMAT;
    end else begin
      it.kind    = udtod_pkg::KIND_SET_RUN;
      it.new_run = ($urandom_range(0, 4) != 0);
    end
    return it;
  endfunction

  // Sends one transaction after a random gap and waits for its acceptance.
  task automatic send_item(udtod_pkg::in_t item, logic has_exp, udtod_pkg::out_t want);
    int unsigned gap;
    if (fast_left != 0) begin
      fast_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) fast_left = $urandom_range(30, 150);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data   <= item;
    exp_given <= has_exp;
    exp_typed <= want;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every owed result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_times.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Writes the count direction while idle, then reads it back.
  task automatic program_direction(logic down);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= udtod_pkg::REG_COUNT_DOWN;
    pwdata  <= {31'b0, down};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_down = down;
    direction_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, down}) begin
      note_error($sformatf("count_down read back %0h, written %0b", prdata, down));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output stall: random bursts with quiet stretches between them.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 4);
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Predicts each accepted transaction and checks each accepted result.
  always @(posedge clk) begin
    udtod_pkg::out_t next_time;
    udtod_pkg::out_t want;
    string           diff;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        next_time = clock_after(clock_model, in_data, model_down);
        if (in_data.kind == udtod_pkg::KIND_TICK && next_time.hour != clock_model.hour)
          hour_changes++;
        clock_model = next_time;
        owed_times.push_back(exp_given ? exp_typed : next_time);
        transactions_sent++;
      end
      if (out_valid && !out_stall) begin
        if (owed_times.size() == 0) begin
          note_error("result arrived with no transaction outstanding");
        end else begin
          want = owed_times.pop_front();
          diff = diff_fields(want, out_data);
          if (diff != "") note_error($sformatf("result %0d:%s", results_checked, diff));
          results_checked++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, owed_times.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    dir_row_t directed [$];
    int       i;
    int       ph;

    // Reset state, saturation and midnight are typed in; the rest is predicted.
    directed.push_back(cfg_row(1'b0));
    // A tick while stopped leaves the reset time alone.
    directed.push_back(exp_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0,
                               udtod_pkg::out_t'{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0}));
    // An all-ones load saturates to 23:59:59 and sets PM.
    directed.push_back(exp_row(udtod_pkg::KIND_SET_TIME, 31, 63, 63, 0, 0,
                               udtod_pkg::out_t'{5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 1'b0}));
    directed.push_back(exp_row(udtod_pkg::KIND_SET_RUN, 0, 0, 0, 0, 1,
                               udtod_pkg::out_t'{5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 1'b1}));
    // Rolling over midnight clears PM.
    directed.push_back(exp_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0,
                               udtod_pkg::out_t'{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1}));
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 11, 59, 59, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));
    // Noon folds to zero with PM; a second switch to twelve-hour leaves it alone.
    directed.push_back(item_row(udtod_pkg::KIND_SET_FORMAT, 0, 0, 0, 1, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_FORMAT, 0, 0, 0, 1, 0));
    // Counting up past 12 in the twelve-hour format goes to one.
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 12, 59, 59, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));
    // A load above 12 in the twelve-hour format, then back to 24-hour.
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 20, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_FORMAT, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 5, 30, 0, 1, 1));
    directed.push_back(item_row(udtod_pkg::KIND_SET_FORMAT, 0, 0, 0, 1, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_RUN, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_RUN, 0, 0, 0, 0, 1));
    // Counting down in the twelve-hour format from hour zero and hour one.
    directed.push_back(cfg_row(1'b1));
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 1, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));
    // Noon with PM stays 12 in the 24-hour format.
    directed.push_back(item_row(udtod_pkg::KIND_SET_FORMAT, 0, 0, 0, 0, 0));
    // Counting down from midnight in 24-hour lands on 23 and flips PM.
    directed.push_back(item_row(udtod_pkg::KIND_SET_TIME, 0, 0, 0, 0, 0));
    directed.push_back(item_row(udtod_pkg::KIND_TICK, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < directed.size(); i++) begin
      if (directed[i].is_cfg) begin
        program_direction(directed[i].cfg_down);
      end else begin
        send_item(directed[i].item, directed[i].has_exp, directed[i].exp);
      end
    end

    // Random phases: up first, then down, then either.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 2) begin
        program_direction(ph[0]);
      end else begin
        program_direction(1'($urandom));
      end
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
    end

    drain();
    if (owed_times.size() != 0) begin
      note_error($sformatf("%0d results never arrived", owed_times.size()));
    end

    $display("summary: %0d transactions, %0d results checked, %0d direction writes",
             transactions_sent, results_checked, direction_writes);
    $display("summary: %0d hour changes by ticks, %0d failures, %0d cycles",
             hour_changes, errors, cycles);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
